/* rtl/itora_pkg.sv */
// Package for the integer to radix ASCII converter.
// Holds the request types, the radix and character constants and the digit mapping.
// Depends on nothing.
package itora_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DIGIT_W         = 6;

    localparam logic [7:0] RADIX_MIN  = 8'd2;
    localparam logic [7:0] RADIX_MAX  = 8'd36;
    localparam logic [7:0] RADIX_DEF  = 8'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'hA;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [63:0] value;
        logic [7:0]         radix;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + {2'b00, d};
        end else begin
            c = ASCII_A + {2'b00, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

/* rtl/integer_to_radix_ascii_top.sv */
// Top level of the integer to radix ASCII converter: bit-serial division by the radix,
// digit buffer and character output register.
// Depends on itora_pkg.
//
//   channel  direction  payload  handshake
//   in       input      t_in     i_in_valid / o_in_stall
//   out      output     t_out    o_out_valid / i_out_stall
//
// Each digit comes from restoring division of the value by the radix, one quotient bit
// per cycle; a leading '-' for a negative radix 10 value goes out first, then each
// character via the digit buffer's registered read port and the output register.
// A new request is taken only after the last character of the previous one has gone.
// Reset is synchronous and active low and clears the control state only.
// A stall on the output holds the current character; the input stalls while busy.
module integer_to_radix_ascii_top #(
    parameter int VALUE_WIDTH = itora_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  itora_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output itora_pkg::t_out  o_out_data
);
    import itora_pkg::*;

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_PUT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [DIGIT_W-1:0]     r_rem;
    logic [DIGIT_W-1:0]     r_base;
    logic                   r_neg;
    logic [IDX_W-1:0]       r_bit;
    logic [IDX_W-1:0]       r_cnt;
    logic                   r_ovalid;
    t_out                   r_out;
    logic [DIGIT_W-1:0]     r_rd_data;
    logic [DIGIT_W-1:0]     r_mem [VALUE_WIDTH];

    logic [VALUE_WIDTH-1:0] in_bits;
    logic [7:0]             in_radix;
    logic                   in_neg;
    logic [DIGIT_W:0]       rem_sh;
    logic                   ge;
    logic [DIGIT_W-1:0]     n_rem;
    logic [VALUE_WIDTH-1:0] n_quo;
    logic                   digit_done;

    always_comb begin
        in_bits  = i_in_data.value[VALUE_WIDTH-1:0];
        in_radix = i_in_data.radix;
        if (in_radix < RADIX_MIN || in_radix > RADIX_MAX) begin
            in_radix = RADIX_DEF;
        end
        in_neg = (in_radix == RADIX_DEF) && in_bits[VALUE_WIDTH-1];
        if (in_neg) begin
            in_bits = ~in_bits + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
        end
        rem_sh     = {r_rem, r_quo[VALUE_WIDTH-1]};
        ge         = rem_sh >= {1'b0, r_base};
        n_rem      = ge ? DIGIT_W'(rem_sh - {1'b0, r_base}) : rem_sh[DIGIT_W-1:0];
        n_quo      = {r_quo[VALUE_WIDTH-2:0], ge};
        digit_done = (r_state == ST_DIV) && (r_bit == '0);
    end

    always_ff @(posedge i_clk) begin
        if (digit_done) begin
            r_mem[r_cnt] <= n_rem;
        end
        r_rd_data <= r_mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_bit    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_quo   <= in_bits;
                        r_rem   <= '0;
                        r_base  <= in_radix[DIGIT_W-1:0];
                        r_neg   <= in_neg;
                        r_bit   <= BIT_LAST;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit != '0) begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                        r_bit <= r_bit - 1'b1;
                    end else if (n_quo != '0) begin
                        r_quo <= n_quo;
                        r_rem <= '0;
                        r_bit <= BIT_LAST;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_neg) begin
                        r_ovalid        <= 1'b1;
                        r_out.character <= ASCII_MINUS;
                        r_out.last      <= 1'b0;
                        r_state         <= ST_SIGN;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_SIGN: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_ovalid        <= 1'b1;
                    r_out.character <= digit_char(r_rd_data);
                    r_out.last      <= (r_cnt == '0);
                    r_state         <= ST_PUT;
                end
                ST_PUT: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_out.last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
